FILE: src/jacobi_poisson_stencil_sweep_defines.svh
// assertion macros for the jacobi five-point stencil sweep
// used by the top level; no other dependencies
`ifndef JACOBI_POISSON_STENCIL_SWEEP_DEFINES_SVH
`define JACOBI_POISSON_STENCIL_SWEEP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define JPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define JPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define JPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/jps_pkg.sv
// shared types and constants for the jacobi five-point stencil sweep
// no dependencies
package jps_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int ValueBits     = 32;
  localparam int RowBits       = 16;
  localparam int GridWidthBits = 11;
  localparam int CoefBits      = 32;
  localparam int SumBits       = ValueBits + 1;
  localparam int QInBits       = 60;
  localparam int QOutBits      = 58;
  localparam int ApbAddrBits   = 5;
  localparam int ApbDataBits   = 32;

  localparam logic [QOutBits-1:0] ProductCap = QOutBits'(1) << 56;

  localparam logic [GridWidthBits-1:0] GridWidthRst  = GridWidthBits'(1024);
  localparam logic [RowBits-1:0]       GridHeightRst = RowBits'(1024);
  localparam logic [CoefBits-1:0]      InvDxSqRst    = CoefBits'(65536);
  localparam logic [CoefBits-1:0]      InvDySqRst    = CoefBits'(65536);
  localparam logic [CoefBits-1:0]      NormCoefRst   = CoefBits'(16384);

  typedef enum logic [2:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_INV_DX_SQ,
    REG_INV_DY_SQ,
    REG_NORM_COEF
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_AHEAD,
    ST_MUL_X,
    ST_WAIT_X,
    ST_MUL_Y,
    ST_WAIT_Y,
    ST_ACC,
    ST_MUL_F,
    ST_WAIT_F,
    ST_OUT_FIRST,
    ST_OUT_LAST
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MSEL_X,
    MSEL_Y,
    MSEL_F
  } mul_sel_e;

  typedef struct packed {
    logic [GridWidthBits-1:0] grid_width;
    logic [RowBits-1:0]       grid_height;
    logic [CoefBits-1:0]      inv_dx_sq;
    logic [CoefBits-1:0]      inv_dy_sq;
    logic [CoefBits-1:0]      norm_coef;
  } cfg_t;

  typedef struct packed {
    logic     accept;
    logic     fetch;
    logic     ahead;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     take_x;
    logic     take_y;
    logic     acc_en;
    logic     out_load;
    logic     out_second;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_first;
    logic last_row;
    logic interior;
    logic mul_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

FILE: src/jacobi_poisson_stencil_sweep.sv
// one jacobi sweep of the five-point poisson stencil over a raster-streamed grid
// top level: apb registers, controller and datapath; uses jps_pkg, jps_ctrl,
// jps_datapath and the assertion macro header
//
// usage
// - input channel (in_valid_i / in_stall_o) carries one grid point per
//   transaction in raster order: old value and right-hand side, q16.16
// - output channel (out_valid_o / out_stall_i) returns the updated point one
//   row up, with its column and row; a last-row input returns a second
//   transaction that passes the arriving point through (last_of_run_o set)
// - one item is worked at a time, through a single shared 32x32 multiplier:
//   an interior point runs the x, y and normalising multiplies in turn, a
//   boundary point none; a last-row point also loads the second result
// - the first result of an item is loaded once its multiplies are done on an
//   interior point, and straight after the look-ahead on a boundary point
// - the three line stores are plain rams with no clearing pass
// - a stalled output holds its result; the controller then waits before
//   loading the next one and keeps in_stall_o high
// - reset clears the counters, the controller and the output valid;
//   registers come up at their reset values; write them only while idle
module jacobi_poisson_stencil_sweep #(
  parameter int MAX_WIDTH = jps_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // apb configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [jps_pkg::ApbAddrBits-1:0]      paddr,
  input  logic [jps_pkg::ApbDataBits-1:0]      pwdata,
  output logic [jps_pkg::ApbDataBits-1:0]      prdata,
  output logic                                 pready,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [jps_pkg::ValueBits-1:0] old_value_i,
  input  logic signed [jps_pkg::ValueBits-1:0] rhs_value_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [jps_pkg::ValueBits-1:0] new_value_o,
  output logic [$clog2(MAX_WIDTH)-1:0]         out_col_o,
  output logic [jps_pkg::RowBits-1:0]          out_row_o,
  output logic                                 is_interior_o,
  output logic                                 last_of_run_o
);

  `include "jacobi_poisson_stencil_sweep_defines.svh"

  localparam int DB = jps_pkg::ApbDataBits;
  localparam int AB = jps_pkg::ApbAddrBits;

  jps_pkg::cfg_t       cfg_q;
  jps_pkg::ctrl_cmd_t  cmd;
  jps_pkg::ctrl_stat_t stat;
  jps_pkg::reg_idx_e   reg_idx;
  logic                cfg_wr;

  // register index is the word address
  assign reg_idx = jps_pkg::reg_idx_e'(paddr[AB-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= jps_pkg::GridWidthRst;
      cfg_q.grid_height <= jps_pkg::GridHeightRst;
      cfg_q.inv_dx_sq   <= jps_pkg::InvDxSqRst;
      cfg_q.inv_dy_sq   <= jps_pkg::InvDySqRst;
      cfg_q.norm_coef   <= jps_pkg::NormCoefRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        jps_pkg::REG_GRID_WIDTH:  cfg_q.grid_width  <= pwdata[jps_pkg::GridWidthBits-1:0];
        jps_pkg::REG_GRID_HEIGHT: cfg_q.grid_height <= pwdata[jps_pkg::RowBits-1:0];
        jps_pkg::REG_INV_DX_SQ:   cfg_q.inv_dx_sq   <= pwdata[jps_pkg::CoefBits-1:0];
        jps_pkg::REG_INV_DY_SQ:   cfg_q.inv_dy_sq   <= pwdata[jps_pkg::CoefBits-1:0];
        jps_pkg::REG_NORM_COEF:   cfg_q.norm_coef   <= pwdata[jps_pkg::CoefBits-1:0];
        default: ;  // unmapped addresses are ignored
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      jps_pkg::REG_GRID_WIDTH:  prdata = DB'(cfg_q.grid_width);
      jps_pkg::REG_GRID_HEIGHT: prdata = DB'(cfg_q.grid_height);
      jps_pkg::REG_INV_DX_SQ:   prdata = DB'(cfg_q.inv_dx_sq);
      jps_pkg::REG_INV_DY_SQ:   prdata = DB'(cfg_q.inv_dy_sq);
      jps_pkg::REG_NORM_COEF:   prdata = DB'(cfg_q.norm_coef);
      default:                  prdata = '0;
    endcase
  end

  // sequencing of each item
  jps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // counters, line stores, arithmetic and output register
  jps_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .old_value_i   (old_value_i),
    .rhs_value_i   (rhs_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .new_value_o   (new_value_o),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .is_interior_o (is_interior_o),
    .last_of_run_o (last_of_run_o)
  );

  // an accepted item keeps the block busy for at least the next cycle
  `JPS_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "item accepted while busy")
  // a stencil result never lies on the first row or column
  `JPS_ASSERT_IMP(a_interior_pos, clk_i, rst_ni, out_valid_o && is_interior_o, (out_col_o != '0) && (out_row_o != '0), "interior result on the grid edge")
  // emitted column stays inside the line store
  `JPS_ASSERT_IMP(a_col_range, clk_i, rst_ni, out_valid_o, 32'(out_col_o) < 32'(MAX_WIDTH), "column beyond the line store")

endmodule

FILE: src/jps_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module jps_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/jps_qmul.sv
// signed q44.16 multiply by an unsigned q16.16 coefficient, floor rounding, magnitude cap
// one shared 32x32 multiplier for both halves; uses jps_pkg
module jps_qmul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [jps_pkg::QInBits-1:0]  a_i,
  input  logic [jps_pkg::CoefBits-1:0]        f_i,
  output logic                                done_o,
  output logic signed [jps_pkg::QOutBits-1:0] res_o
);

  localparam int QIn  = jps_pkg::QInBits;
  localparam int QOut = jps_pkg::QOutBits;

  logic [4:0] step_q, step_d;
  logic neg_q;
  logic [QIn-1:0] m_q;
  logic [31:0] f_q;
  logic [63:0] lo_q, hi_q;
  logic [QOut-1:0] sum_q, sum_d;
  logic ovf_q;
  logic [QOut-1:0] capped;
  logic signed [QOut-1:0] res_q;
  logic [31:0] mul_a;
  logic [63:0] prod;
  logic inc;

  assign step_d = {step_q[3:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  // low half first, then high half
  assign mul_a = step_q[0] ? m_q[31:0] : 32'(m_q[QIn-1:32]);
  assign prod  = {32'b0, mul_a} * {32'b0, f_q};

  assign inc   = neg_q && (lo_q[15:0] != 16'b0);
  assign sum_d = QOut'({hi_q[40:0], 16'b0}) + QOut'(lo_q[63:16]) + QOut'(inc);
  assign capped = (ovf_q || (sum_q > jps_pkg::ProductCap)) ? jps_pkg::ProductCap : sum_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[QIn-1];
      m_q   <= a_i[QIn-1] ? QIn'(-a_i) : QIn'(a_i);
      f_q   <= f_i;
    end
    if (step_q[0]) begin
      lo_q <= prod;
    end
    if (step_q[1]) begin
      hi_q <= prod;
    end
    if (step_q[2]) begin
      sum_q <= sum_d;
      ovf_q <= hi_q[63:40] != 24'b0;
    end
    if (step_q[3]) begin
      res_q <= neg_q ? $signed(~capped + QOut'(1)) : $signed(capped);
    end
  end

  assign done_o = step_q[4];
  assign res_o  = res_q;

endmodule

FILE: src/jps_datapath.sv
// datapath: raster counters, line stores, stencil arithmetic, output register
// uses jps_pkg, jps_ram and jps_qmul
module jps_datapath #(
  parameter int MAX_WIDTH = jps_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  jps_pkg::cfg_t                      cfg_i,
  input  jps_pkg::ctrl_cmd_t                 cmd_i,
  output jps_pkg::ctrl_stat_t                stat_o,
  input  logic signed [jps_pkg::ValueBits-1:0] old_value_i,
  input  logic signed [jps_pkg::ValueBits-1:0] rhs_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [jps_pkg::ValueBits-1:0] new_value_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       out_col_o,
  output logic [jps_pkg::RowBits-1:0]        out_row_o,
  output logic                               is_interior_o,
  output logic                               last_of_run_o
);

  localparam int ColBits = $clog2(MAX_WIDTH);
  localparam int VB      = jps_pkg::ValueBits;
  localparam int RB      = jps_pkg::RowBits;
  localparam int QIn     = jps_pkg::QInBits;
  localparam int QOut    = jps_pkg::QOutBits;
  localparam logic [RB-1:0]      MaxW     = RB'(MAX_WIDTH);
  localparam logic [RB-1:0]      MinDim   = RB'(3);
  localparam logic [ColBits-1:0] LastCol  = ColBits'(MAX_WIDTH - 1);
  localparam logic signed [VB-1:0] SatMax = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] SatMin = {1'b1, {(VB-1){1'b0}}};

  // counters
  logic [ColBits-1:0] col_cnt_q;
  logic [RB-1:0]      row_cnt_q;
  logic [RB-1:0]      gw, w_eff, h_eff, col_p1;
  logic               col_end, last_now, first_now, interior_now;

  // item snapshot
  logic [ColBits-1:0]   col_q;
  logic [RB-1:0]        row_q;
  logic signed [VB-1:0] old_q, rhs_q;
  logic                 has_first_q, last_row_q, interior_q;

  // line store data
  logic [ColBits-1:0]   col_ahead, above_raddr;
  logic [VB-1:0]        above_rd, two_rd, rhs_rd;
  logic signed [VB-1:0] cur_above_q, two_q, rhs_above_q, left_q;
  logic signed [jps_pkg::SumBits-1:0] sx_q, sy_q;

  // arithmetic
  logic signed [QIn-1:0]  mul_a;
  logic [31:0]            mul_f;
  logic                   mul_done;
  logic signed [QOut-1:0] mul_res;
  logic signed [QOut-1:0] tx_q, ty_q;
  logic signed [QIn-1:0]  acc_q;
  logic signed [VB-1:0]   sat_val;
  logic                   ovf_pos, ovf_neg;

  // output register
  logic                 out_valid_q;
  logic signed [VB-1:0] out_val_q;
  logic [ColBits-1:0]   out_col_q;
  logic [RB-1:0]        out_row_q;
  logic                 out_int_q, out_last_q;
  logic                 out_free;

  // effective grid size
  assign gw    = RB'(cfg_i.grid_width);
  assign w_eff = (gw < MinDim) ? MinDim : ((gw > MaxW) ? MaxW : gw);
  assign h_eff = (cfg_i.grid_height < MinDim) ? MinDim : cfg_i.grid_height;

  assign col_p1       = RB'(col_cnt_q) + RB'(1);
  assign col_end      = col_p1 >= w_eff;
  assign last_now     = (17'(row_cnt_q) + 17'd1) >= 17'(h_eff);
  assign first_now    = row_cnt_q != '0;
  assign interior_now = (col_cnt_q != '0) && !col_end &&
                        (row_cnt_q >= RB'(2)) && (row_cnt_q < h_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      has_first_q <= 1'b0;
      last_row_q  <= 1'b0;
      interior_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      has_first_q <= first_now;
      last_row_q  <= last_now;
      interior_q  <= interior_now;
      if (col_end) begin
        col_cnt_q <= '0;
        row_cnt_q <= last_now ? '0 : row_cnt_q + RB'(1);
      end else begin
        col_cnt_q <= col_cnt_q + ColBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_q <= col_cnt_q;
      row_q <= row_cnt_q;
      old_q <= old_value_i;
      rhs_q <= rhs_value_i;
    end
  end

  // the row above is read twice: at the column, then one to the right
  assign col_ahead   = (col_q == LastCol) ? '0 : col_q + ColBits'(1);
  assign above_raddr = cmd_i.ahead ? col_ahead : col_cnt_q;

  jps_ram #(.Width(VB), .Depth(MAX_WIDTH)) u_above (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fetch),
    .waddr_i (col_q),
    .wdata_i (old_q),
    .raddr_i (above_raddr),
    .rdata_o (above_rd)
  );

  jps_ram #(.Width(VB), .Depth(MAX_WIDTH)) u_two_above (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fetch),
    .waddr_i (col_q),
    .wdata_i (above_rd),
    .raddr_i (col_cnt_q),
    .rdata_o (two_rd)
  );

  jps_ram #(.Width(VB), .Depth(MAX_WIDTH)) u_rhs_above (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fetch),
    .waddr_i (col_q),
    .wdata_i (rhs_q),
    .raddr_i (col_cnt_q),
    .rdata_o (rhs_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      cur_above_q <= $signed(above_rd);
      two_q       <= $signed(two_rd);
      rhs_above_q <= $signed(rhs_rd);
    end
    if (cmd_i.ahead) begin
      // left neighbor was the row above at the previous column
      sx_q   <= jps_pkg::SumBits'(left_q) + jps_pkg::SumBits'($signed(above_rd));
      sy_q   <= jps_pkg::SumBits'(two_q) + jps_pkg::SumBits'(old_q);
      left_q <= cur_above_q;
    end
    if (cmd_i.take_x) begin
      tx_q <= mul_res;
    end
    if (cmd_i.take_y) begin
      ty_q <= mul_res;
    end
    if (cmd_i.acc_en) begin
      acc_q <= QIn'(tx_q) + QIn'(ty_q) - QIn'(rhs_above_q);
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      jps_pkg::MSEL_X: begin
        mul_a = QIn'(sx_q);
        mul_f = cfg_i.inv_dx_sq;
      end
      jps_pkg::MSEL_Y: begin
        mul_a = QIn'(sy_q);
        mul_f = cfg_i.inv_dy_sq;
      end
      jps_pkg::MSEL_F: begin
        mul_a = acc_q;
        mul_f = cfg_i.norm_coef;
      end
      default: begin
        mul_a = acc_q;
        mul_f = cfg_i.norm_coef;
      end
    endcase
  end

  jps_qmul u_qmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .f_i     (mul_f),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // saturate to the value range
  assign ovf_pos = !mul_res[QOut-1] && (mul_res[QOut-2:VB-1] != '0);
  assign ovf_neg = mul_res[QOut-1] && !(&mul_res[QOut-2:VB-1]);
  assign sat_val = ovf_pos ? SatMax : (ovf_neg ? SatMin : mul_res[VB-1:0]);

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_col_q <= col_q;
      if (cmd_i.out_second) begin
        out_val_q  <= old_q;
        out_row_q  <= row_q;
        out_int_q  <= 1'b0;
        out_last_q <= 1'b1;
      end else begin
        out_val_q  <= interior_q ? sat_val : cur_above_q;
        out_row_q  <= row_q - RB'(1);
        out_int_q  <= interior_q;
        out_last_q <= !last_row_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_value_o   = out_val_q;
  assign out_col_o     = out_col_q;
  assign out_row_o     = out_row_q;
  assign is_interior_o = out_int_q;
  assign last_of_run_o = out_last_q;

  assign stat_o.has_first = has_first_q;
  assign stat_o.last_row  = last_row_q;
  assign stat_o.interior  = interior_q;
  assign stat_o.mul_done  = mul_done;
  assign stat_o.out_free  = out_free;

endmodule

FILE: src/jps_ctrl.sv
// controller: sequences line store access, multiplies and result emission
// uses jps_pkg
module jps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  jps_pkg::ctrl_stat_t  stat_i,
  output jps_pkg::ctrl_cmd_t   cmd_o
);

  jps_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jps_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = jps_pkg::ST_FETCH;
      end
      jps_pkg::ST_FETCH: state_d = jps_pkg::ST_AHEAD;
      jps_pkg::ST_AHEAD: begin
        if (stat_i.interior) state_d = jps_pkg::ST_MUL_X;
        else if (stat_i.has_first) state_d = jps_pkg::ST_OUT_FIRST;
        else if (stat_i.last_row) state_d = jps_pkg::ST_OUT_LAST;
        else state_d = jps_pkg::ST_IDLE;
      end
      jps_pkg::ST_MUL_X: state_d = jps_pkg::ST_WAIT_X;
      jps_pkg::ST_WAIT_X: begin
        if (stat_i.mul_done) state_d = jps_pkg::ST_MUL_Y;
      end
      jps_pkg::ST_MUL_Y: state_d = jps_pkg::ST_WAIT_Y;
      jps_pkg::ST_WAIT_Y: begin
        if (stat_i.mul_done) state_d = jps_pkg::ST_ACC;
      end
      jps_pkg::ST_ACC: state_d = jps_pkg::ST_MUL_F;
      jps_pkg::ST_MUL_F: state_d = jps_pkg::ST_WAIT_F;
      jps_pkg::ST_WAIT_F: begin
        if (stat_i.mul_done) state_d = jps_pkg::ST_OUT_FIRST;
      end
      jps_pkg::ST_OUT_FIRST: begin
        if (stat_i.out_free) begin
          state_d = stat_i.last_row ? jps_pkg::ST_OUT_LAST : jps_pkg::ST_IDLE;
        end
      end
      jps_pkg::ST_OUT_LAST: begin
        if (stat_i.out_free) state_d = jps_pkg::ST_IDLE;
      end
      default: state_d = jps_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.mul_sel    = jps_pkg::MSEL_X;
    in_stall_o       = 1'b1;
    case (state_q)
      jps_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      jps_pkg::ST_FETCH: cmd_o.fetch = 1'b1;
      jps_pkg::ST_AHEAD: cmd_o.ahead = 1'b1;
      jps_pkg::ST_MUL_X: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = jps_pkg::MSEL_X;
      end
      jps_pkg::ST_WAIT_X: cmd_o.take_x = stat_i.mul_done;
      jps_pkg::ST_MUL_Y: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = jps_pkg::MSEL_Y;
      end
      jps_pkg::ST_WAIT_Y: cmd_o.take_y = stat_i.mul_done;
      jps_pkg::ST_ACC: cmd_o.acc_en = 1'b1;
      jps_pkg::ST_MUL_F: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = jps_pkg::MSEL_F;
      end
      jps_pkg::ST_WAIT_F: cmd_o.mul_sel = jps_pkg::MSEL_F;
      jps_pkg::ST_OUT_FIRST: cmd_o.out_load = stat_i.out_free;
      jps_pkg::ST_OUT_LAST: begin
        cmd_o.out_load   = stat_i.out_free;
        cmd_o.out_second = 1'b1;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule
